/* hdl/ptps_pkg.sv */
// ----------------------------------------------------------------------------
// ptps_pkg
// shared types and codes for the periodic task priority scheduler
// ----------------------------------------------------------------------------
package ptps_pkg;

    localparam int DEF_MAX_TASKS   = 8;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int TASK_ID_W = 3;
    localparam int FIELD_W   = 16;
    localparam int TIME_W    = 32;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_TASKS  = 1'b1;

    // one queued job
    typedef struct packed {
        logic [TASK_ID_W-1:0] task_id;
        logic [FIELD_W-1:0]   remaining;
        logic [TIME_W-1:0]    key;
    } q_entry_t;

endpackage

/* hdl/periodic_task_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_task_priority_scheduler
// preemptive rate monotonic / earliest deadline first scheduler for
// periodic tasks, advanced one tick per tick item
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | content
//  s_*      | in        | s_tvalid/s_tready  | load, tick or restart item
//  m_*      | out       | m_tvalid/m_tready  | one result item per input item
//  cfg_*    | in        | cfg_we             | policy_mode, tasks_in_use
//
//  a load or an unused op goes straight to the result; a restart walks every
//  task slot (read, write next release); a tick checks each task in use,
//  inserts each released job by a tail-first walk through the queue ram and
//  then does the run step; the result item is held while m_tready is low
//  reset clears control state; task table contents are undefined until loaded
//  s_tready is low from acceptance until the result item has been taken
// ----------------------------------------------------------------------------
module periodic_task_priority_scheduler
    import ptps_pkg::*;
#(
    parameter int MAX_TASKS   = DEF_MAX_TASKS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // op[1:0], task_index[4:2], first_release[20:5], task_period_in[36:21],
    // exec_ticks[52:37], relative_deadline_in[68:53], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // running_valid[0], running_task[3:1], slot_time[35:4], job_finished[36],
    // queue_overflow[37], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [3:0]            cfg_wdata
);

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int IW = $clog2(MAX_TASKS + 1);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RST_RD  = 4'd1;
    localparam logic [3:0] S_RST_WR  = 4'd2;
    localparam logic [3:0] S_CHK     = 4'd3;
    localparam logic [3:0] S_EVAL    = 4'd4;
    localparam logic [3:0] S_INS_RD  = 4'd5;
    localparam logic [3:0] S_INS_CMP = 4'd6;
    localparam logic [3:0] S_INS_WR  = 4'd7;
    localparam logic [3:0] S_RUN_RD  = 4'd8;
    localparam logic [3:0] S_RUN_EX  = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    // input fields
    logic [1:0]           in_op;
    logic [TASK_ID_W-1:0] in_idx;
    logic [FIELD_W-1:0]   in_first, in_period, in_exec, in_dl;

    assign in_op     = s_tdata[1:0];
    assign in_idx    = s_tdata[4:2];
    assign in_first  = s_tdata[20:5];
    assign in_period = s_tdata[36:21];
    assign in_exec   = s_tdata[52:37];
    assign in_dl     = s_tdata[68:53];

    // wrap a logical queue position onto the circular buffer
    function automatic logic [QW-1:0] phys(input logic [QW-1:0] h, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        begin
            s = SW'(h) + SW'(k);
            if (s >= SW'(QUEUE_DEPTH))
            begin
                s = s - SW'(QUEUE_DEPTH);
            end
            return QW'(s);
        end
    endfunction

    // control and config
    logic [3:0]          state_reg, state_next;
    logic                policy_reg;
    logic [3:0]          tasks_reg;
    logic [IW-1:0]       i_reg, i_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [QW-1:0]       head_reg, head_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [MAX_TASKS-1:0] nr_valid_reg, nr_valid_next;

    // result register
    logic                 rv_reg, rv_next, jf_reg, jf_next, ov_reg, ov_next;
    logic [TASK_ID_W-1:0] rt_reg, rt_next;
    logic [TIME_W-1:0]    st_reg, st_next;

    // job being inserted
    q_entry_t new_reg, new_next;

    // task table: {offset, period, exec, deadline}
    logic [4*FIELD_W-1:0] task_mem [MAX_TASKS];
    logic [TIME_W-1:0]    nr_mem   [MAX_TASKS];
    logic [4*FIELD_W-1:0] tm_rd;
    logic [TIME_W-1:0]    nr_rd;
    logic                 tm_we, nr_we;
    logic [TW-1:0]        tm_waddr, t_addr;
    logic [TIME_W-1:0]    nr_wdata;

    // queue ram port
    logic     q_we;
    logic [QW-1:0] q_waddr, q_raddr;
    q_entry_t q_wdata, q_rd;

    logic [FIELD_W-1:0] rd_offset, rd_period, rd_exec, rd_dl;
    logic [TIME_W-1:0]  nr_cur;
    logic [7:0]         limit;

    assign rd_offset = tm_rd[4*FIELD_W-1:3*FIELD_W];
    assign rd_period = tm_rd[3*FIELD_W-1:2*FIELD_W];
    assign rd_exec   = tm_rd[2*FIELD_W-1:FIELD_W];
    assign rd_dl     = tm_rd[FIELD_W-1:0];
    assign t_addr    = TW'(i_reg);
    assign nr_cur    = nr_valid_reg[t_addr] ? nr_rd : '0;
    assign limit     = (8'(tasks_reg) < 8'(MAX_TASKS)) ? 8'(tasks_reg) : 8'(MAX_TASKS);

    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            task_mem[tm_waddr] <= {in_first, in_period, in_exec, in_dl};
        end
        if (nr_we)
        begin
            nr_mem[t_addr] <= nr_wdata;
        end
        tm_rd <= task_mem[t_addr];
        nr_rd <= nr_mem[t_addr];
    end

    ptps_qram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (QW)
    ) u_qram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rd)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        time_next     = time_reg;
        nr_valid_next = nr_valid_reg;
        rv_next       = rv_reg;
        rt_next       = rt_reg;
        st_next       = st_reg;
        jf_next       = jf_reg;
        ov_next       = ov_reg;
        new_next      = new_reg;
        tm_we         = 1'b0;
        tm_waddr      = TW'(in_idx);
        nr_we         = 1'b0;
        nr_wdata      = '0;
        q_we          = 1'b0;
        q_waddr       = phys(head_reg, k_reg);
        q_wdata       = new_reg;
        q_raddr       = phys(head_reg, k_reg - CW'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    rv_next    = 1'b0;
                    rt_next    = '0;
                    st_next    = '0;
                    jf_next    = 1'b0;
                    ov_next    = 1'b0;
                    i_next     = '0;
                    state_next = S_OUT;
                    if (in_op == OP_LOAD)
                    begin
                        tm_we = (7'(in_idx) < 7'(MAX_TASKS));
                    end
                    else if (in_op == OP_RESTART)
                    begin
                        count_next = '0;
                        head_next  = '0;
                        time_next  = '0;
                        state_next = S_RST_RD;
                    end
                    else if (in_op == OP_TICK)
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_RST_RD:
            begin
                state_next = S_RST_WR;
            end
            S_RST_WR:
            begin
                nr_we                 = 1'b1;
                nr_wdata              = TIME_W'(rd_offset);
                nr_valid_next[t_addr] = 1'b1;
                i_next                = i_reg + IW'(1);
                state_next = (i_reg == IW'(MAX_TASKS - 1)) ? S_OUT : S_RST_RD;
            end
            S_CHK:
            begin
                state_next = (8'(i_reg) < limit) ? S_EVAL : S_RUN_RD;
            end
            S_EVAL:
            begin
                if (nr_cur == time_reg)
                begin
                    nr_we                 = 1'b1;
                    nr_wdata              = nr_cur + TIME_W'(rd_period);
                    nr_valid_next[t_addr] = 1'b1;
                    new_next.task_id      = TASK_ID_W'(i_reg);
                    new_next.remaining    = rd_exec;
                    new_next.key          = policy_reg ? time_reg + TIME_W'(rd_dl)
                                                       : TIME_W'(rd_period);
                    if (count_reg == CW'(QUEUE_DEPTH))
                    begin
                        ov_next    = 1'b1;
                        i_next     = i_reg + IW'(1);
                        state_next = S_CHK;
                    end
                    else
                    begin
                        k_next     = count_reg;
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_CHK;
                end
            end
            S_INS_RD:
            begin
                state_next = (k_reg == '0) ? S_INS_WR : S_INS_CMP;
            end
            S_INS_CMP:
            begin
                // entries with a larger key move one place towards the tail
                if (q_rd.key > new_reg.key)
                begin
                    q_we       = 1'b1;
                    q_wdata    = q_rd;
                    k_next     = k_reg - CW'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                q_we       = 1'b1;
                count_next = count_reg + CW'(1);
                i_next     = i_reg + IW'(1);
                state_next = S_CHK;
            end
            S_RUN_RD:
            begin
                q_raddr    = head_reg;
                st_next    = time_reg;
                state_next = (count_reg == '0) ? S_OUT : S_RUN_EX;
                time_next  = (count_reg == '0) ? time_reg + TIME_W'(1) : time_reg;
            end
            S_RUN_EX:
            begin
                rv_next   = 1'b1;
                rt_next   = q_rd.task_id;
                time_next = time_reg + TIME_W'(1);
                if (q_rd.remaining <= FIELD_W'(1))
                begin
                    jf_next    = 1'b1;
                    count_next = count_reg - CW'(1);
                    head_next  = phys(head_reg, CW'(1));
                end
                else
                begin
                    q_we              = 1'b1;
                    q_waddr           = head_reg;
                    q_wdata           = q_rd;
                    q_wdata.remaining = q_rd.remaining - FIELD_W'(1);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            policy_reg   <= 1'b0;
            tasks_reg    <= 4'd1;
            i_reg        <= '0;
            k_reg        <= '0;
            count_reg    <= '0;
            head_reg     <= '0;
            time_reg     <= '0;
            nr_valid_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            k_reg        <= k_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            time_reg     <= time_next;
            nr_valid_reg <= nr_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_POLICY)
                begin
                    policy_reg <= cfg_wdata[0];
                end
                else if (cfg_index == CFG_TASKS)
                begin
                    tasks_reg <= cfg_wdata;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        rv_reg  <= rv_next;
        rt_reg  <= rt_next;
        st_reg  <= st_next;
        jf_reg  <= jf_next;
        ov_reg  <= ov_next;
        new_reg <= new_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {2'b00, ov_reg, jf_reg, st_reg, rt_reg, rv_reg};

    // queue never holds more jobs than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a job only runs from a non-empty queue
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN_EX) |-> (count_reg != '0))
        else $error("run step on empty queue");

    // a finished job implies a job ran
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[36]) |-> m_tdata[0])
        else $error("job finished without running");

endmodule

/* hdl/ptps_qram.sv */
// ----------------------------------------------------------------------------
// ptps_qram
// job queue storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ptps_qram
    import ptps_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEF_QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  q_entry_t      wdata,
    input  logic [AW-1:0] raddr,
    output q_entry_t      rdata
);

    q_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
